// File: hw/rtl/hid_report_to_midi_notes_core_assert.svh
// Assertion macros shared by the checker of the HID report to MIDI note core.
`ifndef HID_REPORT_TO_MIDI_NOTES_CORE_ASSERT_SVH
`define HID_REPORT_TO_MIDI_NOTES_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define HRMN_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequence that must hold in the clock cycle after the antecedent.
`define HRMN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hrmn_pkg.sv
// Package of the HID report to MIDI note core: constants, types and the key map.
package hrmn_pkg;

    localparam int SLOT_MAX          = 6;
    localparam int KEY_SLOTS_DEFAULT = 6;
    localparam int KEY_W             = 8;
    localparam int NOTE_W            = 7;
    localparam int VEL_W             = 7;
    localparam int STATUS_W          = 8;
    localparam int IN_DATA_W         = SLOT_MAX * KEY_W;
    localparam int OUT_DATA_W        = 24;

    localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [VEL_W-1:0]    VELOCITY_RESET  = 7'd100;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_report;  // capture a new report, retire the current one
        logic load_out;     // load the output register with the current step
        logic phase;        // 0: note-off pass over old keys, 1: note-on pass
    } cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic hit;          // current step gives a message
        logic last;         // no later step of this report gives a message
        logic out_free;     // output register can take a message this cycle
    } status_t;

    // QWERTY piano map; zero marks an unmapped keycode.
    function automatic logic [NOTE_W-1:0] note_of(input logic [KEY_W-1:0] code);
        logic [NOTE_W-1:0] note;
        unique case (code)
            8'h36:   note = 7'd72;
            8'h10:   note = 7'd71;
            8'h0D:   note = 7'd70;
            8'h11:   note = 7'd69;
            8'h0B:   note = 7'd68;
            8'h05:   note = 7'd67;
            8'h0A:   note = 7'd66;
            8'h19:   note = 7'd65;
            8'h06:   note = 7'd64;
            8'h07:   note = 7'd63;
            8'h1B:   note = 7'd62;
            8'h16:   note = 7'd61;
            8'h1D:   note = 7'd60;
            8'h18:   note = 7'd59;
            8'h24:   note = 7'd58;
            8'h1C:   note = 7'd57;
            8'h23:   note = 7'd56;
            8'h17:   note = 7'd55;
            8'h22:   note = 7'd54;
            8'h15:   note = 7'd53;
            8'h08:   note = 7'd52;
            8'h20:   note = 7'd51;
            8'h1A:   note = 7'd50;
            8'h1F:   note = 7'd49;
            8'h14:   note = 7'd48;
            default: note = '0;
        endcase
        return note;
    endfunction

endpackage

// File: hw/rtl/hrmn_ctrl.sv
// Sequencer of the HID report to MIDI note core: steps the off and on passes.
module hrmn_ctrl #(
    parameter int KEY_SLOTS = hrmn_pkg::KEY_SLOTS_DEFAULT,
    parameter int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hrmn_pkg::status_t status,
    output hrmn_pkg::cmd_t    cmd,
    output logic [SLOT_W-1:0] slot
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic              phase_reg, phase_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        slot_next        = slot_reg;
        advance          = 1'b0;
        s_tready         = 1'b0;
        cmd.load_report  = 1'b0;
        cmd.load_out     = 1'b0;
        cmd.phase        = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_report = 1'b1;
                    phase_next      = 1'b0;
                    slot_next       = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // stall on a hit while the output register is still occupied
                if (status.hit) begin
                    if (status.out_free) begin
                        cmd.load_out = 1'b1;
                        advance      = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
                if (advance) begin
                    if (slot_reg == SLOT_W'(KEY_SLOTS - 1)) begin
                        slot_next = '0;
                        if (phase_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            phase_next = 1'b1;
                        end
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign slot = slot_reg;

endmodule

// File: hw/rtl/hrmn_dp.sv
// Datapath of the HID report to MIDI note core: key stores, compare, output register.
module hrmn_dp #(
    parameter int KEY_SLOTS = hrmn_pkg::KEY_SLOTS_DEFAULT,
    parameter int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [hrmn_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              cfg_wr_en,
    input  logic [hrmn_pkg::VEL_W-1:0]        cfg_wr_data,
    input  hrmn_pkg::cmd_t                    cmd,
    input  logic [SLOT_W-1:0]                 slot,
    output hrmn_pkg::status_t                 status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hrmn_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    logic [hrmn_pkg::KEY_W-1:0]    now_reg  [KEY_SLOTS];
    logic [hrmn_pkg::KEY_W-1:0]    prev_reg [KEY_SLOTS];
    logic [hrmn_pkg::VEL_W-1:0]    vel_reg;
    logic                          valid_reg;
    logic [hrmn_pkg::STATUS_W-1:0] status_reg;
    logic [hrmn_pkg::NOTE_W-1:0]   note_reg;
    logic [hrmn_pkg::VEL_W-1:0]    vel_out_reg;
    logic                          last_reg;

    logic [hrmn_pkg::NOTE_W-1:0]   off_note [KEY_SLOTS];
    logic [hrmn_pkg::NOTE_W-1:0]   on_note  [KEY_SLOTS];
    logic [KEY_SLOTS-1:0]          off_match, on_match;
    logic [KEY_SLOTS-1:0]          off_mask, on_mask;
    logic [KEY_SLOTS-1:0]          off_above, on_above;
    logic [hrmn_pkg::NOTE_W-1:0]   sel_note;

    // Key stores: the new report replaces the current one, which becomes the old one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                now_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end else if (cmd.load_report) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                now_reg[i]  <= s_tdata[i*hrmn_pkg::KEY_W +: hrmn_pkg::KEY_W];
                prev_reg[i] <= now_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg <= hrmn_pkg::VELOCITY_RESET;
        end else if (cfg_wr_en) begin
            vel_reg <= cfg_wr_data;
        end
    end

    // Per slot: a mapped nonzero key that is missing from the other report.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            off_match[i] = 1'b0;
            on_match[i]  = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (now_reg[j] == prev_reg[i]) off_match[i] = 1'b1;
                if (prev_reg[j] == now_reg[i]) on_match[i] = 1'b1;
            end
            off_note[i] = hrmn_pkg::note_of(prev_reg[i]);
            on_note[i]  = hrmn_pkg::note_of(now_reg[i]);
            off_mask[i] = (prev_reg[i] != '0) && !off_match[i] && (off_note[i] != '0);
            on_mask[i]  = (now_reg[i] != '0) && !on_match[i] && (on_note[i] != '0);
        end
    end

    assign off_above = (off_mask >> slot) >> 1;
    assign on_above  = (on_mask >> slot) >> 1;
    assign sel_note  = cmd.phase ? on_note[slot] : off_note[slot];

    assign status.hit      = cmd.phase ? on_mask[slot] : off_mask[slot];
    assign status.last     = cmd.phase ? (on_above == '0)
                                       : ((off_above == '0) && (on_mask == '0));
    assign status.out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status_reg  <= cmd.phase ? hrmn_pkg::STATUS_NOTE_ON : hrmn_pkg::STATUS_NOTE_OFF;
            note_reg    <= sel_note;
            vel_out_reg <= cmd.phase ? vel_reg : '0;
            last_reg    <= status.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, vel_out_reg, note_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule

// File: hw/rtl/hid_report_to_midi_notes_core.sv
// Top level of the HID report to MIDI note core: sequencer plus datapath.
// A message enters the output register in the cycle after its key slot is scanned.
// A request is scanned one key slot per cycle through both passes, holding while a hit waits
// on a full m_ register; the next request is accepted only once the core is back in idle.
// Reset (aresetn low, synchronous) clears the held keys, sets velocity to 100, drops m_tvalid.
module hid_report_to_midi_notes_core #(
    parameter int KEY_SLOTS = hrmn_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request: one keyboard report
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_slot_0 [7:0], key_slot_1 [15:8], ..., key_slot_5 [47:40]
    input  logic [hrmn_pkg::IN_DATA_W-1:0]  s_tdata,
    // note_on_velocity register
    input  logic                            cfg_wr_en,
    input  logic [hrmn_pkg::VEL_W-1:0]      cfg_wr_data,
    // result: one MIDI note message
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status_byte [7:0], note_number [14:8], velocity_byte [21:15], zero [23:22]
    output logic [hrmn_pkg::OUT_DATA_W-1:0] m_tdata,
    // last_of_run
    output logic                            m_tlast
);

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    hrmn_pkg::cmd_t    cmd;
    hrmn_pkg::status_t status;
    logic [SLOT_W-1:0] slot;

    // Sequencer: accept the report, walk old slots for note-offs, then new slots for note-ons.
    hrmn_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .slot     (slot)
    );

    // Datapath: compare the two reports, map keys to notes, drive the output register.
    hrmn_dp #(
        .KEY_SLOTS (KEY_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .slot        (slot),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: hw/rtl/hrmn_checker.sv
// Port checker of the HID report to MIDI note core and its bind.
`include "hid_report_to_midi_notes_core_assert.svh"

module hrmn_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hrmn_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    logic [hrmn_pkg::STATUS_W-1:0] msg_status;
    logic [hrmn_pkg::NOTE_W-1:0]   msg_note;
    logic [hrmn_pkg::VEL_W-1:0]    msg_vel;
    logic [1:0]                    msg_pad;
    logic                          msg_off;
    logic                          msg_on;

    assign msg_status = m_tdata[7:0];
    assign msg_note   = m_tdata[14:8];
    assign msg_vel    = m_tdata[21:15];
    assign msg_pad    = m_tdata[23:22];
    assign msg_off    = (msg_status == hrmn_pkg::STATUS_NOTE_OFF);
    assign msg_on     = (msg_status == hrmn_pkg::STATUS_NOTE_ON);

    `HRMN_ASSERT_NEXT(a_one_request_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted back to back")
    `HRMN_ASSERT_ALWAYS(a_status_code, aclk, aresetn, !m_tvalid || ((msg_off || msg_on) && msg_pad == 2'b00), "bad status byte")
    `HRMN_ASSERT_ALWAYS(a_off_zero_velocity, aclk, aresetn, !(m_tvalid && msg_off) || msg_vel == 7'd0, "note-off with nonzero velocity")
    `HRMN_ASSERT_ALWAYS(a_note_range, aclk, aresetn, !m_tvalid || (msg_note >= 7'd48 && msg_note <= 7'd72), "note outside key map")
    `HRMN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled message changed")

endmodule

bind hid_report_to_midi_notes_core hrmn_checker u_hrmn_checker (.*);

// File: tb/sv/tb_hid_report_to_midi_notes_core.sv
// Self-checking bench for the HID report to MIDI note core: keyboard reports in, note messages out.
module tb_hid_report_to_midi_notes_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS   = 4;
    localparam int LIMIT_NS      = 5_000_000;
    // A request occupies the core through both scan passes even when it yields no message,
    // so let them and some margin pass before touching the velocity register.
    localparam int SETTLE_CYCLES = 24;
    localparam int PIANO_KEYS    = 25;
    localparam int LOWEST_NOTE   = 48;
    localparam int KEY_W         = hrmn_pkg::KEY_W;
    localparam int NOTE_W        = hrmn_pkg::NOTE_W;
    localparam int VEL_W         = hrmn_pkg::VEL_W;
    localparam int STATUS_W      = hrmn_pkg::STATUS_W;
    localparam int SLOT_MAX      = hrmn_pkg::SLOT_MAX;
    localparam int IN_DATA_W     = hrmn_pkg::IN_DATA_W;
    localparam int OUT_DATA_W    = hrmn_pkg::OUT_DATA_W;

    // Keycodes of the piano map, lowest byte is note 48, highest byte note 72.
    localparam logic [PIANO_KEYS*KEY_W-1:0] PIANO_CODES = {
        8'h36, 8'h10, 8'h0D, 8'h11, 8'h0B, 8'h05, 8'h0A, 8'h19, 8'h06, 8'h07,
        8'h1B, 8'h16, 8'h1D, 8'h18, 8'h24, 8'h1C, 8'h23, 8'h17, 8'h22, 8'h15,
        8'h08, 8'h20, 8'h1A, 8'h1F, 8'h14
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    vel;
        logic                last;
    } midi_msg_t;

    typedef struct {
        logic [IN_DATA_W-1:0] keys;
        bit                   hold_for_drain;   // wait until all messages are out
    } report_req_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  cfg_wr_en   = 1'b0;
    logic [VEL_W-1:0]      cfg_wr_data = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Predictor state: keys of the last accepted report and the velocity register.
    logic [IN_DATA_W-1:0]  held_keys   = '0;
    logic [VEL_W-1:0]      note_on_vel = hrmn_pkg::VELOCITY_RESET;

    report_req_t           pending_reports[$];
    midi_msg_t             note_expect_q[$];
    report_req_t           next_req;
    logic [IN_DATA_W-1:0]  last_queued = '0;
    int                    sender_idle_pct = 0;
    int                    recv_idle_pct   = 0;
    int                    mismatch_count  = 0;

    hid_report_to_midi_notes_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #CLK_HALF_NS aclk = ~aclk;

    // Look a keycode up in the piano map; zero means unmapped.
    function automatic logic [NOTE_W-1:0] piano_note(input logic [KEY_W-1:0] code);
        logic [NOTE_W-1:0] n;
        n = '0;
        for (int i = 0; i < PIANO_KEYS; i++) begin
            if (PIANO_CODES[i*KEY_W +: KEY_W] == code) begin
                n = NOTE_W'(LOWEST_NOTE + i);
            end
        end
        return n;
    endfunction

    function automatic bit report_holds(input logic [IN_DATA_W-1:0] keys,
                                        input logic [KEY_W-1:0] code);
        bit found;
        found = 1'b0;
        for (int i = 0; i < SLOT_MAX; i++) begin
            if (keys[i*KEY_W +: KEY_W] == code) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Work out the note messages of one report, queue them, and retire the old keys.
    function automatic void predict_note_messages(input logic [IN_DATA_W-1:0] now_keys);
        midi_msg_t         run_q[$];
        midi_msg_t         msg;
        logic [KEY_W-1:0]  k;
        logic [NOTE_W-1:0] n;
        // Note-off pass: old keys that were released.
        for (int i = 0; i < SLOT_MAX; i++) begin
            k = held_keys[i*KEY_W +: KEY_W];
            n = piano_note(k);
            if (k != '0 && !report_holds(now_keys, k) && n != '0) begin
                msg.status = hrmn_pkg::STATUS_NOTE_OFF;
                msg.note   = n;
                msg.vel    = '0;
                msg.last   = 1'b0;
                run_q.push_back(msg);
            end
        end
        // Note-on pass: new keys that were not held; repeated codes repeat.
        for (int i = 0; i < SLOT_MAX; i++) begin
            k = now_keys[i*KEY_W +: KEY_W];
            n = piano_note(k);
            if (k != '0 && !report_holds(held_keys, k) && n != '0) begin
                msg.status = hrmn_pkg::STATUS_NOTE_ON;
                msg.note   = n;
                msg.vel    = note_on_vel;
                msg.last   = 1'b0;
                run_q.push_back(msg);
            end
        end
        for (int j = 0; j < run_q.size(); j++) begin
            msg      = run_q[j];
            msg.last = (j == run_q.size() - 1);
            note_expect_q.push_back(msg);
        end
        held_keys = now_keys;
    endfunction

    function automatic logic [IN_DATA_W-1:0] slots6(
        input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1, input logic [KEY_W-1:0] k2,
        input logic [KEY_W-1:0] k3, input logic [KEY_W-1:0] k4, input logic [KEY_W-1:0] k5);
        return {k5, k4, k3, k2, k1, k0};
    endfunction

    function automatic void queue_report(input logic [IN_DATA_W-1:0] keys, input bit hold);
        report_req_t r;
        r.keys           = keys;
        r.hold_for_drain = hold;
        pending_reports.push_back(r);
        last_queued = keys;
    endfunction

    // Mostly piano keys, some empty slots, some arbitrary codes.
    function automatic logic [KEY_W-1:0] pick_key();
        int mode;
        int idx;
        mode = $urandom_range(99);
        idx  = $urandom_range(PIANO_KEYS - 1);
        if (mode < 65) begin
            return PIANO_CODES[idx*KEY_W +: KEY_W];
        end else if (mode < 80) begin
            return '0;
        end
        return KEY_W'($urandom_range(255));
    endfunction

    // Evolve the keyboard like a player would; now and then release all or send noise.
    function automatic logic [IN_DATA_W-1:0] next_report(input logic [IN_DATA_W-1:0] prior);
        logic [IN_DATA_W-1:0] r;
        int                   mode;
        r    = prior;
        mode = $urandom_range(99);
        if (mode < 10) begin
            r = IN_DATA_W'({$urandom, $urandom});
        end else if (mode < 15) begin
            r = '0;
        end else begin
            for (int i = 0; i < SLOT_MAX; i++) begin
                if ($urandom_range(99) < 35) begin
                    r[i*KEY_W +: KEY_W] = pick_key();
                end
            end
        end
        return r;
    endfunction

    task automatic queue_random_reports(input int count);
        for (int i = 0; i < count; i++) begin
            // Drain the core once mid-phase and now and then at random.
            queue_report(next_report(last_queued), (i == count / 2) || ($urandom_range(49) == 0));
        end
    endtask

    // Block until every request is taken, every message is out, and the core is quiet.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_reports.size() != 0 || s_tvalid || note_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_velocity(input logic [VEL_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        note_on_vel  = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    endtask

    // Request driver: present the next report, hold it until taken, predict on accept.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_note_messages(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reports.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                    !(pending_reports[0].hold_for_drain && note_expect_q.size() != 0)) begin
                    next_req = pending_reports.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.keys;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Message sink: stall at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each accepted message with the oldest expected one.
    always @(posedge aclk) begin
        midi_msg_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (note_expect_q.size() == 0) begin
                report_mismatch("unexpected message", int'(m_tdata), 0);
            end else begin
                want = note_expect_q.pop_front();
                if (m_tdata[7:0] != want.status)
                    report_mismatch("status_byte", int'(m_tdata[7:0]), int'(want.status));
                if (m_tdata[14:8] != want.note)
                    report_mismatch("note_number", int'(m_tdata[14:8]), int'(want.note));
                if (m_tdata[21:15] != want.vel)
                    report_mismatch("velocity_byte", int'(m_tdata[21:15]), int'(want.vel));
                if (m_tdata[23:22] != 2'b00)
                    report_mismatch("tdata padding", int'(m_tdata[23:22]), 0);
                if (m_tlast != want.last)
                    report_mismatch("last_of_run", int'(m_tlast), int'(want.last));
            end
        end
    end

    // Stimulus: directed reports at reset velocity, then three random phases.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct = 38;
        recv_idle_pct   = 67;
        // Empty report straight out of reset: nothing changes.
        queue_report(slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        // Lowest note on, then off again.
        queue_report(slots6(8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        queue_report(slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        // Highest note in the last slot.
        queue_report(slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h36), 1'b0);
        // Release one key and press six.
        queue_report(slots6(8'h1D, 8'h16, 8'h1B, 8'h07, 8'h06, 8'h19), 1'b0);
        // Swap all six keys: the longest run of messages.
        queue_report(slots6(8'h0A, 8'h05, 8'h0B, 8'h11, 8'h0D, 8'h10), 1'b1);
        // Same report again: no change.
        queue_report(slots6(8'h0A, 8'h05, 8'h0B, 8'h11, 8'h0D, 8'h10), 1'b0);
        // One code in every slot: repeated note-ons.
        queue_report(slots6(8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14), 1'b0);
        queue_report(slots6(8'h14, 8'h14, 8'h14, 8'h00, 8'h00, 8'h00), 1'b0);
        // Release all: repeated note-offs.
        queue_report(slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        // Unmapped keys: silent, yet held.
        queue_report(slots6(8'h04, 8'hFF, 8'h80, 8'h01, 8'h37, 8'h00), 1'b0);
        queue_report(slots6(8'hFF, 8'h14, 8'h04, 8'h00, 8'h00, 8'h00), 1'b0);
        queue_report(slots6(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
        // Alternating bit patterns mixed with piano keys.
        queue_report(slots6(8'hAA, 8'h55, 8'h1F, 8'h20, 8'hAA, 8'h55), 1'b0);
        queue_report(slots6(8'h55, 8'hAA, 8'h1F, 8'h24, 8'h08, 8'h23), 1'b0);
        queue_report(slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        wait_drained();

        write_velocity(7'd127);
        queue_random_reports(140);
        wait_drained();

        sender_idle_pct = 67;
        recv_idle_pct   = 38;
        write_velocity(7'd0);
        queue_random_reports(140);
        wait_drained();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        write_velocity(VEL_W'($urandom_range(126, 1)));
        queue_random_reports(130);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #LIMIT_NS;
        $display("== FAIL ==");
        $finish;
    end

endmodule
